FILE: hw/rtl/text_console_writer_unit_macros.svh
// Assertion macros for the text console writer checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/tcw_pkg.sv
// Package for the text console writer: constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int TCW_COLUMNS   = 80;
  localparam int TCW_TEXT_ROWS = 24;
  localparam int TCW_TAB_WIDTH = 8;

  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } tcw_command_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_EMIT
  } tcw_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] cursor_position;
    logic        scrolled;
  } tcw_out_t;

  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic clear_run;
    logic scroll_run;
    logic load_out;
  } tcw_ctrl_t;

  typedef struct packed {
    logic is_clear;
    logic need_scroll;
    logic sweep_done;
    logic scroll_done;
  } tcw_status_t;

endpackage

FILE: hw/rtl/text_console_writer_unit.sv
// Text console writer: one put, read, clear or no-op transaction at a time.
// The result is loaded into the output register in EMIT once the output is
// free; no new item is taken before that. A scroll copies the screen up
// one row, cell by cell; a clear zeroes all (TEXT_ROWS+1)*COLUMNS cells,
// one cell per cycle. After reset a clear pass holds in_stall_o high; config
// writes are taken at any time. Depends on tcw_pkg, tcw_ctrl, tcw_datapath.
`timescale 1ns / 1ps

module text_console_writer_unit #(
  parameter int COLUMNS   = tcw_pkg::TCW_COLUMNS,
  parameter int TEXT_ROWS = tcw_pkg::TCW_TEXT_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::TCW_TAB_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import tcw_pkg::*;

  tcw_ctrl_t   ctrl;
  tcw_status_t status;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  tcw_datapath #(
    .COLUMNS   (COLUMNS),
    .TEXT_ROWS (TEXT_ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

FILE: hw/rtl/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives the datapath through tcw_ctrl_t.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_ctrl_t   ctrl_o
);
  import tcw_pkg::*;

  tcw_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.sweep_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_clear) state_d = ST_CLEAR;
          else if (status_i.need_scroll) state_d = ST_SCROLL;
          else state_d = ST_EMIT;
        end
      end
      ST_SCROLL: begin
        if (status_i.scroll_done) state_d = ST_EMIT;
      end
      ST_CLEAR: begin
        if (status_i.sweep_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.accept     = accept;
    ctrl_o.cnt_clr    = accept;
    ctrl_o.clear_run  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    ctrl_o.scroll_run = (state_q == ST_SCROLL);
    ctrl_o.load_out   = (state_q == ST_EMIT) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/tcw_datapath.sv
// Datapath for the text console writer: screen memory, cursor, sweep counter,
// attribute register and output register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int COLUMNS   = tcw_pkg::TCW_COLUMNS,
  parameter int TEXT_ROWS = tcw_pkg::TCW_TEXT_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::TCW_TAB_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcw_pkg::tcw_in_t     in_data_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  input  tcw_pkg::tcw_ctrl_t   ctrl_i,
  output tcw_pkg::tcw_status_t status_o,
  output tcw_pkg::tcw_out_t    out_data_o
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = (TEXT_ROWS + 1) * COLUMNS;
  localparam int MOVE_COUNT = TEXT_ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int ROW_W      = $clog2(TEXT_ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rdata_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [7:0]        attr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              scrolled_q, scrolled_d;
  logic              hit_q, hit_d;
  tcw_out_t          out_q;

  logic [ADDR_W-1:0] pos;
  logic [15:0]       pos_wide;
  logic              row_last;
  logic [ROW_W-1:0]  row_inc;
  logic [COL_W:0]    col_sum;
  logic              is_put;
  logic              is_plain;
  logic              in_range;
  logic              sc;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CNT_W-1:0]  scroll_raddr;
  logic [CNT_W-1:0]  scroll_waddr;

  assign pos      = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
  assign pos_wide = 16'(pos);
  assign row_last = (row_q == ROW_W'(TEXT_ROWS - 1));
  assign row_inc  = row_last ? row_q : row_q + ROW_W'(1);
  assign col_sum  = {1'b0, col_q} + (COL_W + 1)'(TAB_WIDTH);
  assign is_put   = (in_data_i.command == CMD_PUT);
  assign is_plain = is_put && (in_data_i.char_code != CHAR_NEWLINE)
                    && (in_data_i.char_code != CHAR_RETURN)
                    && (in_data_i.char_code != CHAR_TAB);
  assign in_range = int'(in_data_i.cell_index) < CELL_COUNT;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    sc    = 1'b0;
    case (in_data_i.command)
      CMD_PUT: begin
        if (in_data_i.char_code == CHAR_NEWLINE) begin
          row_d = row_inc;
          col_d = '0;
          sc    = row_last;
        end else if (in_data_i.char_code == CHAR_RETURN) begin
          col_d = '0;
        end else if (in_data_i.char_code == CHAR_TAB) begin
          if (col_sum < (COL_W + 1)'(COLUMNS)) begin
            col_d = col_sum[COL_W-1:0];
          end else begin
            row_d = row_inc;
            col_d = COL_W'(col_sum - (COL_W + 1)'(COLUMNS));
            sc    = row_last;
          end
        end else if (col_q == COL_W'(COLUMNS - 1)) begin
          row_d = row_inc;
          col_d = '0;
          sc    = row_last;
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      CMD_CLEAR: begin
        row_d = '0;
        col_d = '0;
      end
      default: begin
        row_d = row_q;
        col_d = col_q;
      end
    endcase
  end

  assign scrolled_d = sc;
  assign hit_d      = (in_data_i.command == CMD_READ) && in_range;

  assign status_o.is_clear    = (in_data_i.command == CMD_CLEAR);
  assign status_o.need_scroll = sc;
  assign status_o.sweep_done  = (cnt_q == CNT_W'(CELL_COUNT - 1));
  assign status_o.scroll_done = (cnt_q == CNT_W'(MOVE_COUNT));

  assign scroll_raddr = cnt_q + CNT_W'(COLUMNS);
  assign scroll_waddr = cnt_q - CNT_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {attr_q, in_data_i.char_code};
    if (ctrl_i.clear_run) begin
      we    = 1'b1;
      waddr = cnt_q[ADDR_W-1:0];
      wdata = '0;
    end else if (ctrl_i.scroll_run) begin
      we    = (cnt_q != '0);
      waddr = scroll_waddr[ADDR_W-1:0];
      wdata = rdata_q;
    end else if (ctrl_i.accept && is_plain) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = ADDR_W'(in_data_i.cell_index);
    if (ctrl_i.scroll_run) begin
      re    = (cnt_q < CNT_W'(MOVE_COUNT));
      raddr = scroll_raddr[ADDR_W-1:0];
    end else if (ctrl_i.accept && hit_d) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      attr_q     <= ATTR_RESET;
      cnt_q      <= '0;
      scrolled_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_data_i;
      if (ctrl_i.accept) begin
        row_q      <= row_d;
        col_q      <= col_d;
        scrolled_q <= scrolled_d;
        hit_q      <= hit_d;
      end
      if (ctrl_i.cnt_clr) cnt_q <= '0;
      else if (ctrl_i.clear_run || ctrl_i.scroll_run) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q.cell_data       <= hit_q ? rdata_q : 16'h0000;
      out_q.cursor_position <= pos_wide[10:0];
      out_q.scrolled        <= scrolled_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_unit_macros.svh.
`timescale 1ns / 1ps
`include "text_console_writer_unit_macros.svh"

module tcw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input tcw_pkg::tcw_out_t out_data_i
)
;
  import tcw_pkg::*;

  `TCW_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i, "stalled result dropped")
  `TCW_ASSERT(a_out_stable, out_valid_i && out_stall_i |=> $stable(out_data_i), "stalled result changed")
  `TCW_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_i |=> in_stall_i, "second item taken while busy")
  `TCW_ASSERT_RST(a_reset_quiet, !rst_ni |=> (!out_valid_i && in_stall_i), "activity during reset")

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

FILE: tb/sv/tb_top.sv
// Testbench for text_console_writer_unit: directed and random put, read, clear and
// no-op transactions with random idling on both sides, checked against a shadow screen.
// Depends on tcw_pkg and text_console_writer_unit.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  class console_mirror;
    localparam int CELL_TOTAL = (TCW_TEXT_ROWS + 1) * TCW_COLUMNS;

    logic [15:0]  cells [CELL_TOTAL];
    int unsigned  row;
    int unsigned  col;
    logic [7:0]   attribute;
    tcw_out_t     expected_status [$];
    int unsigned  failures;
    int unsigned  results_seen;
    int unsigned  puts;
    int unsigned  reads;
    int unsigned  clears;
    int unsigned  scrolls;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row = 0;
      col = 0;
      attribute = ATTR_RESET;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    function int unsigned cursor_spot();
      return row * TCW_COLUMNS + col;
    endfunction

    function logic advance_row();
      row++;
      if (row >= TCW_TEXT_ROWS) begin
        row = TCW_TEXT_ROWS - 1;
        for (int i = 0; i < TCW_TEXT_ROWS * TCW_COLUMNS; i++) cells[i] = cells[i + TCW_COLUMNS];
        scrolls++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_command(tcw_in_t cmd);
      tcw_out_t want;
      want = '0;
      case (cmd.command)
        CMD_PUT: begin
          puts++;
          if (cmd.char_code == CHAR_NEWLINE) begin
            want.scrolled = advance_row();
            col = 0;
          end else if (cmd.char_code == CHAR_RETURN) begin
            col = 0;
          end else if (cmd.char_code == CHAR_TAB) begin
            if (col + TCW_TAB_WIDTH < TCW_COLUMNS) begin
              col += TCW_TAB_WIDTH;
            end else begin
              want.scrolled = advance_row();
              col = col + TCW_TAB_WIDTH - TCW_COLUMNS;
            end
          end else begin
            cells[row * TCW_COLUMNS + col] = {attribute, cmd.char_code};
            if (col >= TCW_COLUMNS - 1) begin
              col = 0;
              want.scrolled = advance_row();
            end else begin
              col++;
            end
          end
        end
        CMD_READ: begin
          reads++;
          if (cmd.cell_index < CELL_TOTAL) want.cell_data = cells[cmd.cell_index];
        end
        CMD_CLEAR: begin
          clears++;
          foreach (cells[i]) cells[i] = '0;
          row = 0;
          col = 0;
        end
        default: begin
        end
      endcase
      want.cursor_position = 11'(row * TCW_COLUMNS + col);
      expected_status.push_back(want);
    endfunction

    function void flag(string msg);
      if (failures < 10) $display("%0t ERROR: %s", $realtime, msg);
      failures++;
    endfunction

    function void check_status(tcw_out_t got);
      tcw_out_t want;
      results_seen++;
      if (expected_status.size() == 0) begin
        flag($sformatf("unexpected transaction cell=%h cursor=%0d scrolled=%0d",
                       got.cell_data, got.cursor_position, got.scrolled));
        return;
      end
      want = expected_status.pop_front();
      if (got.cell_data !== want.cell_data || got.cursor_position !== want.cursor_position ||
          got.scrolled !== want.scrolled)
        flag($sformatf("cell exp %h got %h, cursor exp %0d got %0d, scrolled exp %0d got %0d",
                       want.cell_data, got.cell_data, want.cursor_position,
                       got.cursor_position, want.scrolled, got.scrolled));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  tcw_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  tcw_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  console_mirror mirror = new();
  bit            steady_flow = 1'b0;
  int unsigned   attr_writes = 0;

  text_console_writer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (15) #10_000_000;
    $display("text_console_writer_unit verification failed");
    $finish;
  end

  function automatic tcw_in_t make_cmd(tcw_command_e op, logic [7:0] ch, logic [10:0] idx);
    tcw_in_t c;
    c.command = op;
    c.char_code = ch;
    c.cell_index = idx;
    return c;
  endfunction

  function automatic tcw_in_t draw_command(int unsigned clear_odds);
    tcw_in_t     c;
    int unsigned pick;
    int          spot;
    c.command = CMD_PUT;
    c.char_code = 8'($urandom);
    c.cell_index = 11'($urandom);
    pick = $urandom_range(0, 999);
    if (pick < clear_odds) begin
      c.command = CMD_CLEAR;
    end else if (pick < 30) begin
      c.command = CMD_NOP;
    end else if (pick < 250) begin
      c.command = CMD_READ;
      if ($urandom_range(0, 2) != 0) begin
        spot = int'(mirror.cursor_spot()) - int'($urandom_range(0, 200));
        c.cell_index = 11'((spot < 0) ? 0 : spot);
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 12) c.char_code = CHAR_NEWLINE;
      else if (pick < 18) c.char_code = CHAR_RETURN;
      else if (pick < 28) c.char_code = CHAR_TAB;
      else if (pick >= 35) c.char_code = 8'($urandom_range(8'h20, 8'h7e));
    end
    return c;
  endfunction

  task automatic send_command(input tcw_in_t cmd);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= cmd;
    do @(negedge clk_i); while (in_stall_o);
    mirror.note_command(cmd);
    @(posedge clk_i);
    gap = steady_flow ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle_queue();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.pending() != 0);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    mirror.set_attribute(value);
    attr_writes++;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned stall_cycles;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall_cycles = steady_flow ? 0 : $urandom_range(0, 14);
      if (stall_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (!out_valid_o);
      mirror.check_status(out_data_o);
      @(posedge clk_i);
    end
  end

  initial begin
    logic [7:0] attr;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(make_cmd(CMD_READ, 8'h00, 11'd0));
    send_command(make_cmd(CMD_READ, 8'h00, 11'h7ff));
    send_command(make_cmd(CMD_NOP, 8'hff, 11'h7ff));
    send_command(make_cmd(CMD_PUT, 8'h00, 11'h000));
    send_command(make_cmd(CMD_PUT, 8'hff, 11'h7ff));
    send_command(make_cmd(CMD_READ, 8'h00, 11'd0));
    send_command(make_cmd(CMD_READ, 8'h00, 11'd1));
    send_command(make_cmd(CMD_PUT, CHAR_RETURN, 11'd0));
    send_command(make_cmd(CMD_PUT, 8'h41, 11'd0));
    repeat (10) send_command(make_cmd(CMD_PUT, CHAR_TAB, 11'd0));
    send_command(make_cmd(CMD_PUT, CHAR_NEWLINE, 11'd0));
    send_command(make_cmd(CMD_READ, 8'h00, 11'd1999));
    send_command(make_cmd(CMD_CLEAR, 8'h00, 11'd0));
    send_command(make_cmd(CMD_READ, 8'h00, 11'd1));

    for (int p = 0; p < 8; p++) begin
      settle_queue();
      attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hff : (p == 2) ? 8'h80 : 8'($urandom);
      write_attribute(attr);
      steady_flow = (p == 2 || p == 5);
      for (int n = 0; n < 212; n++) begin
        if ($urandom_range(0, 149) == 0) settle_queue();
        send_command(draw_command(2));
      end
    end

    settle_queue();
    repeat (50) @(posedge clk_i);
    $display("covered %0d puts, %0d reads, %0d clears, %0d scrolls",
             mirror.puts, mirror.reads, mirror.clears, mirror.scrolls);
    $display("checked %0d results across %0d attribute settings, %0d failures",
             mirror.results_seen, attr_writes + 1, mirror.failures);
    if (mirror.failures == 0 && mirror.pending() == 0) begin
      $display("text_console_writer_unit verification clean");
    end else begin
      $display("text_console_writer_unit verification failed");
    end
    $finish;
  end
endmodule
